// ===== hw/rtl/rau_pkg.sv =====
package rau_pkg;

  localparam int OP_W   = 32;   // operand bits used, 8..32
  localparam int MAG_W  = 32;   // magnitude width into the multiplier
  localparam int WORD_W = 64;
  localparam int CNT_W  = 7;
  localparam int SH_W   = 6;

  localparam logic [WORD_W-1:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WORD_W-1:0] NEG_MAX = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_CMP = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_GCD = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] res;
  } alu_res_t;

endpackage

// ===== hw/rtl/rational_arithmetic_unit_core.sv =====
// Channel  | Ports                                         | Transfer
// command  | start, action, a_num, a_den, b_num, b_den     | start && !busy
// result   | res_num, res_den, is_less/equal/greater,      | done (one cycle)
//          | zero_den_error, overflow                      |
// Steps: errors and unused actions finish straight from idle; compare two multiplies;
// multiply/divide two multiplies, a gcd and two divides; add/subtract a gcd, two divides,
// three multiplies, a gcd and two divides, on the one shared multiply/divide/gcd unit.
// Reset clears the sequencer and the strobe. busy is high while an item is
// worked on; the receiver cannot stall, each result is flagged by done for one cycle.
module rational_arithmetic_unit_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  action,
  input  logic signed [31:0] a_num,
  input  logic signed [31:0] a_den,
  input  logic signed [31:0] b_num,
  input  logic signed [31:0] b_den,
  output logic        busy,
  output logic        done,
  output logic signed [63:0] res_num,
  output logic [62:0] res_den,
  output logic        is_less,
  output logic        is_equal,
  output logic        is_greater,
  output logic        zero_den_error,
  output logic        overflow
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_G1   = 11'b000_0000_0010,
    S_Q1   = 11'b000_0000_0100,
    S_Q2   = 11'b000_0000_1000,
    S_M1   = 11'b000_0001_0000,
    S_M2   = 11'b000_0010_0000,
    S_M3   = 11'b000_0100_0000,
    S_G2   = 11'b000_1000_0000,
    S_D1   = 11'b001_0000_0000,
    S_D2   = 11'b010_0000_0000,
    S_SPARE = 11'b100_0000_0000
  } state_t;

  localparam int W = rau_pkg::WORD_W;
  localparam int M = rau_pkg::MAG_W;

  state_t            state;
  rau_pkg::action_t  act;
  logic              issued;
  logic [M-1:0]      am, ad, bm, bd, q1, q2;
  logic              an_neg, bn_neg, neg;
  logic [W-1:0]      g, mag, den;

  rau_pkg::alu_cmd_t ucmd;
  rau_pkg::alu_res_t ursp;

  rau_alu u_alu (.clk(clk), .rst(rst), .cmd(ucmd), .rsp(ursp));

  // operand decode
  logic signed [M:0] an_s, ad_s, bn_s, bd_s;
  logic [M:0]        an_a, ad_a, bn_a, bd_a;
  logic              err, in_an_neg, in_bn_neg;

  assign an_s = (M+1)'($signed(a_num[rau_pkg::OP_W-1:0]));
  assign ad_s = (M+1)'($signed(a_den[rau_pkg::OP_W-1:0]));
  assign bn_s = (M+1)'($signed(b_num[rau_pkg::OP_W-1:0]));
  assign bd_s = (M+1)'($signed(b_den[rau_pkg::OP_W-1:0]));
  assign an_a = an_s[M] ? -an_s : an_s;
  assign ad_a = ad_s[M] ? -ad_s : ad_s;
  assign bn_a = bn_s[M] ? -bn_s : bn_s;
  assign bd_a = bd_s[M] ? -bd_s : bd_s;
  assign in_an_neg = (an_s[M] ^ ad_s[M]) && (an_s != '0);
  assign in_bn_neg = (bn_s[M] ^ bd_s[M]) && (bn_s != '0);
  assign err = (ad_s == '0) || (bd_s == '0) ||
               (action == rau_pkg::ACT_DIV && bn_s == '0);

  function automatic logic [W-1:0] zx(input logic [M-1:0] v);
    zx = W'(v);
  endfunction

  // unit command
  always_comb begin
    ucmd.start = (state != S_IDLE) && !issued;
    ucmd.op    = rau_pkg::OP_MUL;
    ucmd.a     = '0;
    ucmd.b     = '0;
    unique case (state)
      S_G1: begin ucmd.op = rau_pkg::OP_GCD; ucmd.a = zx(ad); ucmd.b = zx(bd); end
      S_Q1: begin ucmd.op = rau_pkg::OP_DIV; ucmd.a = zx(ad); ucmd.b = g; end
      S_Q2: begin ucmd.op = rau_pkg::OP_DIV; ucmd.a = zx(bd); ucmd.b = g; end
      S_M1: begin
        case (act)
          rau_pkg::ACT_MUL: begin ucmd.a = zx(ad); ucmd.b = zx(bd); end
          rau_pkg::ACT_DIV: begin ucmd.a = zx(ad); ucmd.b = zx(bm); end
          rau_pkg::ACT_CMP: begin ucmd.a = zx(bm); ucmd.b = zx(ad); end
          default:          begin ucmd.a = zx(q1); ucmd.b = zx(bd); end
        endcase
      end
      S_M2: begin
        case (act)
          rau_pkg::ACT_MUL: begin ucmd.a = zx(am); ucmd.b = zx(bm); end
          rau_pkg::ACT_DIV, rau_pkg::ACT_CMP: begin ucmd.a = zx(am); ucmd.b = zx(bd); end
          default:          begin ucmd.a = zx(am); ucmd.b = zx(q2); end
        endcase
      end
      S_M3: begin ucmd.a = zx(bm); ucmd.b = zx(q1); end
      S_G2: begin ucmd.op = rau_pkg::OP_GCD; ucmd.a = mag; ucmd.b = den; end
      S_D1: begin ucmd.op = rau_pkg::OP_DIV; ucmd.a = mag; ucmd.b = g; end
      S_D2: begin ucmd.op = rau_pkg::OP_DIV; ucmd.a = den; ucmd.b = g; end
      default: ucmd.start = 1'b0;
    endcase
  end

  // add/subtract combine: ta in mag, tb from the unit
  logic          tb_neg, sum_neg;
  logic [W-1:0]  sum_mag;
  always_comb begin
    tb_neg = (act == rau_pkg::ACT_SUB) ? ((bm != '0) && !bn_neg) : bn_neg;
    if (an_neg == tb_neg) begin
      sum_mag = mag + ursp.res;
      sum_neg = an_neg;
    end else if (mag >= ursp.res) begin
      sum_mag = mag - ursp.res;
      sum_neg = an_neg;
    end else begin
      sum_mag = ursp.res - mag;
      sum_neg = tb_neg;
    end
  end

  // final range check: mag reduced, den from the unit
  logic          fin_neg, fin_ovf;
  always_comb begin
    fin_neg = neg && (mag != '0);
    fin_ovf = (ursp.res > rau_pkg::POS_MAX) ||
              (!fin_neg && mag > rau_pkg::POS_MAX) ||
              (fin_neg && mag > rau_pkg::NEG_MAX);
  end

  // compare over cross products: lm from the unit, rm in den
  logic c_less, c_equal;
  always_comb begin
    c_equal = (an_neg == bn_neg) && (ursp.res == den);
    c_less  = (an_neg && !bn_neg) ||
              (!an_neg && !bn_neg && ursp.res < den) ||
              (an_neg && bn_neg && ursp.res > den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ucmd.start) issued <= 1'b1;
      if (ursp.done)  issued <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            res_num        <= '0;
            res_den        <= '0;
            is_less        <= 1'b0;
            is_equal       <= 1'b0;
            is_greater     <= 1'b0;
            zero_den_error <= 1'b0;
            overflow       <= 1'b0;
            am     <= an_a[M-1:0];
            ad     <= ad_a[M-1:0];
            bm     <= bn_a[M-1:0];
            bd     <= bd_a[M-1:0];
            an_neg <= in_an_neg;
            bn_neg <= in_bn_neg;
            neg    <= in_an_neg ^ in_bn_neg;
            act    <= rau_pkg::action_t'(action);
            if (action > rau_pkg::ACT_CMP) begin
              done <= 1'b1;
            end else if (err) begin
              zero_den_error <= 1'b1;
              done           <= 1'b1;
            end else if (action == rau_pkg::ACT_ADD || action == rau_pkg::ACT_SUB) begin
              state <= S_G1;
            end else begin
              state <= S_M1;
            end
          end
        end
        S_G1: if (ursp.done) begin g <= ursp.res; state <= S_Q1; end
        S_Q1: if (ursp.done) begin q1 <= ursp.res[M-1:0]; state <= S_Q2; end
        S_Q2: if (ursp.done) begin q2 <= ursp.res[M-1:0]; state <= S_M1; end
        S_M1: if (ursp.done) begin den <= ursp.res; state <= S_M2; end
        S_M2: if (ursp.done) begin
          mag <= ursp.res;
          if (act == rau_pkg::ACT_CMP) begin
            is_less    <= c_less;
            is_equal   <= c_equal;
            is_greater <= !c_less && !c_equal;
            done       <= 1'b1;
            state      <= S_IDLE;
          end else if (act == rau_pkg::ACT_ADD || act == rau_pkg::ACT_SUB) begin
            state <= S_M3;
          end else begin
            state <= S_G2;
          end
        end
        S_M3: if (ursp.done) begin
          mag   <= sum_mag;
          neg   <= sum_neg;
          state <= S_G2;
        end
        S_G2: if (ursp.done) begin
          g     <= (ursp.res == '0) ? W'(1) : ursp.res;
          state <= S_D1;
        end
        S_D1: if (ursp.done) begin mag <= ursp.res; state <= S_D2; end
        S_D2: if (ursp.done) begin
          if (fin_ovf) begin
            overflow <= 1'b1;
          end else begin
            res_num <= fin_neg ? -mag : mag;
            res_den <= ursp.res[W-2:0];
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = state != S_IDLE;

  assert property (@(posedge clk) disable iff (rst) ursp.done |-> state != S_IDLE)
    else $error("unit result with no item in work");
  assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({is_less, is_equal, is_greater}))
    else $error("compare flags not exclusive");
  assert property (@(posedge clk) disable iff (rst)
    (done && (overflow || zero_den_error)) |-> (res_num == '0 && res_den == '0))
    else $error("error result carries a value");
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("transfer dropped");

endmodule

// ===== hw/rtl/rau_alu.sv =====
// Shared iterative unit: shift-add multiply (32 steps), restoring divide
// (64 steps, quotient), binary gcd (one compare/subtract or shift a step).
module rau_alu (
  input  logic              clk,
  input  logic              rst,
  input  rau_pkg::alu_cmd_t cmd,
  output rau_pkg::alu_res_t rsp
);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_DIV  = 4'b0100,
    U_GCD  = 4'b1000
  } ustate_t;

  ustate_t state;
  logic [rau_pkg::WORD_W-1:0] x, y, z;
  logic [rau_pkg::WORD_W:0]   rem;
  logic [rau_pkg::CNT_W-1:0]  cnt;
  logic [rau_pkg::SH_W-1:0]   k;
  logic                       done;
  logic [rau_pkg::WORD_W-1:0] res;

  logic [rau_pkg::WORD_W:0]   rem_sh;
  logic                       fits;

  assign rem_sh = {rem[rau_pkg::WORD_W-1:0], x[rau_pkg::WORD_W-1]};
  assign fits   = rem_sh >= {1'b0, y};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (cmd.start) begin
            x   <= cmd.a;
            y   <= cmd.b;
            z   <= '0;
            rem <= '0;
            cnt <= '0;
            k   <= '0;
            unique case (cmd.op)
              rau_pkg::OP_MUL: state <= U_MUL;
              rau_pkg::OP_DIV: state <= U_DIV;
              default:         state <= U_GCD;
            endcase
          end
        end
        U_MUL: begin
          // x: shifted multiplicand, y: multiplier bits, z: accumulator
          if (y[0]) z <= z + x;
          x   <= {x[rau_pkg::WORD_W-2:0], 1'b0};
          y   <= {1'b0, y[rau_pkg::WORD_W-1:1]};
          cnt <= cnt + 1'b1;
          if (cnt == rau_pkg::CNT_W'(rau_pkg::MAG_W - 1)) begin
            res   <= y[0] ? z + x : z;
            done  <= 1'b1;
            state <= U_IDLE;
          end
        end
        U_DIV: begin
          // x shifts out the dividend and takes in the quotient
          rem <= fits ? rem_sh - {1'b0, y} : rem_sh;
          x   <= {x[rau_pkg::WORD_W-2:0], fits};
          cnt <= cnt + 1'b1;
          if (cnt == rau_pkg::CNT_W'(rau_pkg::WORD_W - 1)) begin
            res   <= {x[rau_pkg::WORD_W-2:0], fits};
            done  <= 1'b1;
            state <= U_IDLE;
          end
        end
        U_GCD: begin
          if (x == '0) begin
            res   <= y << k;
            done  <= 1'b1;
            state <= U_IDLE;
          end else if (y == '0) begin
            res   <= x << k;
            done  <= 1'b1;
            state <= U_IDLE;
          end else if (!x[0] && !y[0]) begin
            x <= x >> 1;
            y <= y >> 1;
            k <= k + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x >= y) begin
            x <= x - y;
          end else begin
            y <= y - x;
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.res  = res;

  assert property (@(posedge clk) disable iff (rst) done |-> state == U_IDLE)
    else $error("unit done while still stepping");
  assert property (@(posedge clk) disable iff (rst)
    (state == U_IDLE && cmd.start) |=> state != U_IDLE)
    else $error("unit start not taken");
  assert property (@(posedge clk) disable iff (rst)
    (state == U_MUL || state == U_DIV) |-> cnt < rau_pkg::CNT_W'(rau_pkg::WORD_W))
    else $error("step count past end");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] an, ad, bn, bd;
  } frac_pair_t;

  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    logic lt, eq, gt, zde, ovf;
  } rau_result_t;

  localparam logic [2:0] ACT_BAD_LO  = 3'd5;
  localparam logic [2:0] ACT_BAD_MID = 3'd6;
  localparam logic [2:0] ACT_BAD_HI  = 3'd7;
  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  action = '0;
  logic signed [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic        busy, done;
  logic signed [63:0] res_num;
  logic [62:0] res_den;
  logic        is_less, is_equal, is_greater, zero_den_error, overflow;

  frac_pair_t  pending_ops[$];
  rau_result_t expected_results[$];
  int          n_errors = 0;
  int          n_cycles = 0;
  int          idle_left = 0;
  bit          stim_done = 1'b0;
  bit          no_idle = 1'b0;

  rational_arithmetic_unit_core u_dut (
    .clk, .rst, .start, .action, .a_num, .a_den, .b_num, .b_den,
    .busy, .done, .res_num, .res_den, .is_less, .is_equal, .is_greater,
    .zero_den_error, .overflow
  );

  always #4 clk = ~clk;

  function automatic logic signed [63:0] sext_op(logic [31:0] v);
    logic [31:0] m;
    m = v << (32 - rau_pkg::OP_W);
    return 64'(signed'(m)) >>> (32 - rau_pkg::OP_W);
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic void reduce_into(bit neg, logic [63:0] mag, logic [63:0] den,
                                      ref rau_result_t r);
    logic [63:0] g;
    g = gcd64(mag, den);
    if (g == 0) g = 1;
    mag = mag / g;
    den = den / g;
    if (mag == 0) neg = 0;
    if (den > rau_pkg::POS_MAX || (!neg && mag > rau_pkg::POS_MAX) ||
        (neg && mag > rau_pkg::NEG_MAX)) begin
      r.ovf = 1'b1;
      return;
    end
    r.num = neg ? (64'd0 - mag) : mag;
    r.den = den[62:0];
  endfunction

  function automatic rau_result_t predict_rational(frac_pair_t it);
    rau_result_t r;
    logic signed [63:0] an, ad, bn, bd, l, rr;
    logic [63:0] am, bm, g, lcm, ta, tb;
    bit an_neg, bn_neg, tb_neg;
    r = '{default: '0};
    an = sext_op(it.an); ad = sext_op(it.ad);
    bn = sext_op(it.bn); bd = sext_op(it.bd);
    if (it.act > rau_pkg::ACT_CMP) return r;
    if (ad == 0 || bd == 0 || (it.act == rau_pkg::ACT_DIV && bn == 0)) begin
      r.zde = 1'b1;
      return r;
    end
    if (ad < 0) begin an = -an; ad = -ad; end
    if (bd < 0) begin bn = -bn; bd = -bd; end
    if (it.act == rau_pkg::ACT_CMP) begin
      l = an * bd;
      rr = bn * ad;
      r.lt = l < rr; r.eq = l == rr; r.gt = l > rr;
      return r;
    end
    an_neg = an < 0; bn_neg = bn < 0;
    am = an_neg ? -an : an;
    bm = bn_neg ? -bn : bn;
    if (it.act == rau_pkg::ACT_ADD || it.act == rau_pkg::ACT_SUB) begin
      g = gcd64(ad, bd);
      lcm = (ad / g) * bd;
      ta = am * (bd / g);
      tb = bm * (ad / g);
      tb_neg = (it.act == rau_pkg::ACT_SUB) ? !bn_neg : bn_neg;
      if (an_neg == tb_neg) reduce_into(an_neg, ta + tb, lcm, r);
      else if (ta >= tb) reduce_into(an_neg, ta - tb, lcm, r);
      else reduce_into(tb_neg, tb - ta, lcm, r);
    end else if (it.act == rau_pkg::ACT_MUL) begin
      reduce_into(an_neg != bn_neg, am * bm, ad * bd, r);
    end else begin
      reduce_into(an_neg != bn_neg, am * bd, ad * bm, r);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, n_cycles);
    n_errors++;
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return $urandom_range(0, 2000) - 1000;
      3: return 32'(signed'(16'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [2:0] act, logic [31:0] an, ad, bn, bd);
    frac_pair_t it;
    it.act = act; it.an = an; it.ad = ad; it.bn = bn; it.bd = bd;
    pending_ops.push_back(it);
  endtask

  initial begin
    frac_pair_t it;
    // extremes, each action, zero denominators, zero results, unused actions
    queue_op(rau_pkg::ACT_ADD, 1, 2, 1, 3);
    queue_op(rau_pkg::ACT_SUB, 1, 2, 1, 2);
    queue_op(rau_pkg::ACT_MUL, -3, 4, 4, -3);
    queue_op(rau_pkg::ACT_DIV, 5, 7, 0, 3);
    queue_op(rau_pkg::ACT_DIV, 5, 7, -10, 14);
    queue_op(rau_pkg::ACT_CMP, 1, 3, 2, 6);
    queue_op(rau_pkg::ACT_CMP, -1, 3, 1, -4);
    queue_op(rau_pkg::ACT_CMP, 7, -2, 1, 1);
    queue_op(rau_pkg::ACT_ADD, 1, 0, 1, 1);
    queue_op(rau_pkg::ACT_CMP, 1, 1, 1, 0);
    queue_op(rau_pkg::ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_op(rau_pkg::ACT_SUB, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1);
    queue_op(rau_pkg::ACT_MUL, 32'h8000_0000, 1, 32'h8000_0000, 1);
    queue_op(rau_pkg::ACT_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_op(rau_pkg::ACT_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_op(rau_pkg::ACT_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h7FFF_FFFF);
    queue_op(rau_pkg::ACT_MUL, 0, -5, 3, 4);
    queue_op(rau_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_op(ACT_BAD_LO, 1, 2, 3, 4);
    queue_op(ACT_BAD_MID, 1, 0, 3, 4);
    queue_op(ACT_BAD_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 550; i++) begin
      it.act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
      it.an = rand_operand(); it.ad = rand_operand();
      it.bn = rand_operand(); it.bd = rand_operand();
      if ($urandom_range(0, 3) == 0) it.bn = it.an;
      if ($urandom_range(0, 3) == 0) it.bd = it.ad;
      if (it.ad == 0 && $urandom_range(0, 3) != 0) it.ad = 1;
      if (it.bd == 0 && $urandom_range(0, 3) != 0) it.bd = 1;
      pending_ops.push_back(it);
    end
    stim_done = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == 9) rst <= 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        expected_results.push_back(predict_rational(pending_ops.pop_front()));
      end
      if (pending_ops.size() < 60) no_idle <= 1'b1;
      if (!(start && !busy) && start) begin
        // hold current item
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        idle_left <= $urandom_range(0, 7);
        start <= 1'b0;
      end else if (pending_ops.size() > 0 && !(start && !busy && pending_ops.size() == 0))
      begin
        start <= 1'b1;
        action <= pending_ops[0].act;
        a_num <= pending_ops[0].an;
        a_den <= pending_ops[0].ad;
        b_num <= pending_ops[0].bn;
        b_den <= pending_ops[0].bd;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rau_result_t w;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", res_num, 64'd0);
      end else begin
        w = expected_results.pop_front();
        if (res_num !== w.num) report_mismatch("res_num", res_num, w.num);
        if (res_den !== w.den) report_mismatch("res_den", 64'(res_den), 64'(w.den));
        if (is_less !== w.lt) report_mismatch("is_less", 64'(is_less), 64'(w.lt));
        if (is_equal !== w.eq) report_mismatch("is_equal", 64'(is_equal), 64'(w.eq));
        if (is_greater !== w.gt)
          report_mismatch("is_greater", 64'(is_greater), 64'(w.gt));
        if (zero_den_error !== w.zde)
          report_mismatch("zero_den_error", 64'(zero_den_error), 64'(w.zde));
        if (overflow !== w.ovf) report_mismatch("overflow", 64'(overflow), 64'(w.ovf));
      end
    end
  end

  initial begin
    wait (stim_done && !rst);
    wait (pending_ops.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (700) @(posedge clk);
    if (n_errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    wait (n_cycles >= CYCLE_LIMIT);
    $display("TIMEOUT at cycle %0d", n_cycles);
    $display("Test completed with failures");
    $finish;
  end

endmodule
